FILE: hw/rtl/autn_pkg.sv
// types, constants and helper functions shared by the timestamp normalizer
package autn_pkg;

    localparam int unsigned DIV_W = 96;
    localparam int unsigned DSR_W = 32;
    localparam int unsigned CNT_W = $clog2(DIV_W);

    localparam logic [63:0] SMAX          = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] US_PER_SECOND = 32'd1000000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SCALE = 2'd1;
    localparam logic [1:0] ST_NORM_OVF  = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic        [63:0] ntp_time;
        logic signed [63:0] pts_ticks;
        logic signed [63:0] dts_ticks;
        logic        [31:0] pts_scale;
        logic        [31:0] dts_scale;
        logic               is_video;
        logic               has_wall_clock;
        logic signed [63:0] wall_clock_us;
        logic        [31:0] mpu_sequence;
        logic               discontinuity_in;
    } unit_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [63:0] norm_pts;
        logic signed [63:0] norm_dts;
        logic               discontinuity_out;
        logic               clock_emit;
        logic signed [63:0] clock_us;
        logic               clock_overflow;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic add_ovf(input logic [63:0] a, input logic [63:0] b,
                                     input logic [63:0] r);
        return (a[63] == b[63]) && (r[63] != a[63]);
    endfunction

    function automatic logic sub_ovf(input logic [63:0] a, input logic [63:0] b,
                                     input logic [63:0] r);
        return (a[63] != b[63]) && (r[63] != a[63]);
    endfunction

endpackage

FILE: hw/rtl/autn_mul.sv
// shared 32x32 unsigned multiplier with registered product
module autn_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'b0, a} * {32'b0, b};
    end

    assign p = p_reg;
endmodule

FILE: hw/rtl/autn_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module autn_div (
    input  logic               clk,
    input  logic               rst_n,
    input  autn_pkg::div_req_t req,
    output autn_pkg::div_rsp_t rsp
);
    import autn_pkg::*;

    logic [DIV_W-1:0] dvd_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else if (req.start)
        begin
            dvd_reg  <= req.dividend;
            dsr_reg  <= req.divisor;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;
endmodule

FILE: hw/rtl/access_unit_timestamp_normalizer.sv
// top level: access unit timestamp normalizer with shared multiplier and divider
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+-------------------
//  unit     | in        | unit_valid / unit_ready     | autn_pkg::unit_t
//  result   | out       | result_valid / result_ready | autn_pkg::result_t
//
// one beat in gives one beat out. a unit holds the block from its accepting cycle until
// its result is moved to the output register; a video unit with a wall clock also gets
// its clock mapping, a second rescale, and a bad timescale goes straight to DONE. the
// bit-serial divider, run once per rescale, is the longest step.
// reset clears the timeline origin and the last emitted mpu sequence.
// the finished result sits in an output register, so the next unit is taken
// while it waits; a unit finishing before the old result leaves holds in DONE.
module access_unit_timestamp_normalizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              unit_valid,
    output logic              unit_ready,
    input  autn_pkg::unit_t   unit,
    output logic              result_valid,
    input  logic              result_ready,
    output autn_pkg::result_t result
);
    import autn_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_DIFF, S_DABS, S_DMW, S_DMF, S_DSUM, S_DTICK,
        S_RSET, S_RMLO, S_RMHI, S_RDIV, S_RWAIT, S_BASE, S_SUMS, S_CLK, S_DONE
    } state_t;

    state_t      state_reg;
    unit_t       u_reg;
    result_t     wk_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    result_t     wk_init;

    // timeline origin and broadcast clock tracking
    logic        origin_valid_reg;
    logic [63:0] origin_ntp_reg;
    logic [63:0] origin_pts_reg;
    logic [31:0] origin_scale_reg;
    logic        last_seq_valid_reg;
    logic [31:0] last_seq_reg;

    // working values
    logic [64:0] d_reg;
    logic        neg_reg;
    logic [63:0] diff_reg;
    logic [63:0] whole_reg;
    logic [64:0] sum_reg;
    logic [63:0] ticks_reg;
    logic [63:0] offs_reg;
    logic [63:0] base_reg;
    logic [63:0] us_reg;

    // rescale operands
    logic [63:0] rs_val_reg;
    logic        rs_neg_reg;
    logic [31:0] rs_src_reg;
    logic [31:0] rs_dst_reg;
    logic        rs_pts_reg;
    logic [63:0] lo_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [63:0] base_d;
    logic [63:0] npts_d;
    logic [63:0] ndts_d;
    logic [63:0] clock_d;
    logic [63:0] q_lo;

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_DMW:
            begin
                mul_a = diff_reg[63:32];
                mul_b = u_reg.pts_scale;
            end
            S_DMF:
            begin
                mul_a = diff_reg[31:0];
                mul_b = u_reg.pts_scale;
            end
            S_RMLO:
            begin
                mul_a = rs_val_reg[31:0];
                mul_b = rs_dst_reg;
            end
            S_RMHI:
            begin
                mul_a = rs_val_reg[63:32];
                mul_b = rs_dst_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // fresh working result: everything clear but the discontinuity mark
    always_comb
    begin
        wk_init                   = '0;
        wk_init.discontinuity_out = unit.discontinuity_in;
    end

    autn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // mag * dst as a 96-bit dividend, divided by src
    assign div_req.start    = (state_reg == S_RDIV);
    assign div_req.dividend = {mul_p, 32'b0} + {32'b0, lo_reg};
    assign div_req.divisor  = rs_src_reg;

    autn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q_lo    = div_rsp.quotient[63:0];
    assign base_d  = ticks_reg - offs_reg;
    assign npts_d  = base_reg + u_reg.pts_ticks;
    assign ndts_d  = base_reg + u_reg.dts_ticks;
    assign clock_d = u_reg.wall_clock_us + us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            res_valid_reg      <= 1'b0;
            origin_valid_reg   <= 1'b0;
            origin_ntp_reg     <= '0;
            origin_pts_reg     <= '0;
            origin_scale_reg   <= 32'd1;
            last_seq_valid_reg <= 1'b0;
            last_seq_reg       <= '0;
        end
        else
        begin
            // in DONE the output slot is handled by the DONE arm
            if (res_valid_reg && result_ready && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (unit_valid)
                    begin
                        u_reg     <= unit;
                        wk_reg    <= wk_init;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (u_reg.pts_scale == '0 || u_reg.dts_scale != u_reg.pts_scale)
                    begin
                        wk_reg.status <= ST_BAD_SCALE;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        if (!origin_valid_reg)
                        begin
                            origin_valid_reg <= 1'b1;
                            origin_ntp_reg   <= u_reg.ntp_time;
                            origin_pts_reg   <= u_reg.pts_ticks;
                            origin_scale_reg <= u_reg.pts_scale;
                        end
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    d_reg     <= {1'b0, u_reg.ntp_time} - {1'b0, origin_ntp_reg};
                    state_reg <= S_DABS;
                end
                S_DABS:
                begin
                    // borrow means the unit is before the origin
                    neg_reg   <= d_reg[64];
                    diff_reg  <= d_reg[64] ? (64'd0 - d_reg[63:0]) : d_reg[63:0];
                    state_reg <= S_DMW;
                end
                S_DMW:
                begin
                    state_reg <= S_DMF;
                end
                S_DMF:
                begin
                    whole_reg <= mul_p;
                    state_reg <= S_DSUM;
                end
                S_DSUM:
                begin
                    // fractional seconds: keep the integer part of frac * scale
                    sum_reg   <= {1'b0, whole_reg} + {33'b0, mul_p[63:32]};
                    state_reg <= S_DTICK;
                end
                S_DTICK:
                begin
                    if (sum_reg > {1'b0, SMAX})
                    begin
                        wk_reg.status <= ST_NORM_OVF;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        ticks_reg  <= neg_reg ? (64'd0 - sum_reg[63:0]) : sum_reg[63:0];
                        rs_val_reg <= origin_pts_reg;
                        rs_src_reg <= origin_scale_reg;
                        rs_dst_reg <= u_reg.pts_scale;
                        rs_pts_reg <= 1'b0;
                        state_reg  <= S_RSET;
                    end
                end
                S_RSET:
                begin
                    rs_neg_reg <= rs_val_reg[63];
                    rs_val_reg <= rs_val_reg[63] ? (64'd0 - rs_val_reg) : rs_val_reg;
                    state_reg  <= S_RMLO;
                end
                S_RMLO:
                begin
                    state_reg <= S_RMHI;
                end
                S_RMHI:
                begin
                    lo_reg    <= mul_p;
                    state_reg <= S_RDIV;
                end
                S_RDIV:
                begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        // floor(mag * dst / src) must fit a signed 64-bit magnitude
                        if (div_rsp.quotient[DIV_W-1:63] != '0)
                        begin
                            if (rs_pts_reg)
                            begin
                                wk_reg.clock_overflow <= 1'b1;
                            end
                            else
                            begin
                                wk_reg.status <= ST_NORM_OVF;
                            end
                            state_reg <= S_DONE;
                        end
                        else if (rs_pts_reg)
                        begin
                            us_reg    <= rs_neg_reg ? (64'd0 - q_lo) : q_lo;
                            state_reg <= S_CLK;
                        end
                        else
                        begin
                            offs_reg  <= rs_neg_reg ? (64'd0 - q_lo) : q_lo;
                            state_reg <= S_BASE;
                        end
                    end
                end
                S_BASE:
                begin
                    if (sub_ovf(ticks_reg, offs_reg, base_d))
                    begin
                        wk_reg.status <= ST_RANGE;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        base_reg  <= base_d;
                        state_reg <= S_SUMS;
                    end
                end
                S_SUMS:
                begin
                    if (add_ovf(base_reg, u_reg.pts_ticks, npts_d) ||
                        add_ovf(base_reg, u_reg.dts_ticks, ndts_d))
                    begin
                        wk_reg.status <= ST_RANGE;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        wk_reg.norm_pts <= npts_d;
                        wk_reg.norm_dts <= ndts_d;
                        if (u_reg.is_video && u_reg.has_wall_clock)
                        begin
                            rs_val_reg <= u_reg.pts_ticks;
                            rs_src_reg <= u_reg.pts_scale;
                            rs_dst_reg <= US_PER_SECOND;
                            rs_pts_reg <= 1'b1;
                            state_reg  <= S_RSET;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CLK:
                begin
                    if (add_ovf(u_reg.wall_clock_us, us_reg, clock_d))
                    begin
                        wk_reg.clock_overflow <= 1'b1;
                    end
                    else
                    begin
                        wk_reg.clock_us <= clock_d;
                        // new sequence, first mapping, or discontinuity
                        if (!last_seq_valid_reg || last_seq_reg != u_reg.mpu_sequence ||
                            u_reg.discontinuity_in)
                        begin
                            last_seq_valid_reg <= 1'b1;
                            last_seq_reg       <= u_reg.mpu_sequence;
                            wk_reg.clock_emit  <= 1'b1;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!res_valid_reg || result_ready)
                    begin
                        res_reg       <= wk_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign unit_ready   = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef ASSERT_OFF
    a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.norm_pts == '0 && result.norm_dts == '0)
        else $error("normalized fields set on a flagged result");

    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.clock_emit |->
            result.status == ST_OK && !result.clock_overflow && last_seq_valid_reg)
        else $error("clock emitted on a failed unit");

    a_origin_latch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(origin_valid_reg) |-> $past(state_reg) == S_CHECK)
        else $error("origin latched outside the scale check");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_ready |=> state_reg == S_CHECK)
        else $error("accepted unit not checked");
`endif
endmodule

FILE: tb/access_unit_timestamp_normalizer_checker.sv
// checker for the timestamp normalizer: watches both channels, predicts and compares
module access_unit_timestamp_normalizer_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              unit_valid,
    input  logic              unit_ready,
    input  autn_pkg::unit_t   unit,
    input  logic              result_valid,
    input  logic              result_ready,
    input  autn_pkg::result_t result,
    output int                errors,
    output int                pending,
    output int                results_seen
);
    import autn_pkg::*;

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;

    // timeline state
    logic        org_valid;
    logic [63:0] org_ntp;
    logic [63:0] org_pts;
    logic [31:0] org_scale;
    logic        seq_valid;
    logic [31:0] seq_last;

    result_t expected_results[$];

    function automatic logic ntp_to_ticks(input logic [63:0] cur, input logic [63:0] org,
                                          input logic [31:0] scale, output logic [63:0] res);
        logic        neg;
        logic [63:0] diff, secs, frac, whole, part, mag;
        logic [127:0] prod;
        neg  = cur < org;
        diff = neg ? org - cur : cur - org;
        secs = diff >> 32;
        frac = {32'd0, diff[31:0]};
        if (scale != 0 && secs > SMAX / {32'd0, scale})
            return 1'b0;
        whole = secs * {32'd0, scale};
        prod  = {64'd0, frac} * {96'd0, scale};
        part  = prod[95:32];
        if (whole > SMAX - part)
            return 1'b0;
        mag = whole + part;
        res = neg ? 64'd0 - mag : mag;
        return 1'b1;
    endfunction

    function automatic logic rescale_ticks(input logic [63:0] val, input logic [31:0] src,
                                           input logic [31:0] dst, output logic [63:0] res);
        logic        neg;
        logic [63:0] mag, whole, rem, scaled;
        neg = (val & SIGN_MASK) != 0;
        mag = neg ? 64'd0 - val : val;
        if (src == 0)
            return 1'b0;
        whole = mag / {32'd0, src};
        rem   = mag % {32'd0, src};
        if (dst != 0 && whole > SMAX / {32'd0, dst})
            return 1'b0;
        scaled = whole * {32'd0, dst} + (rem * {32'd0, dst}) / {32'd0, src};
        if (scaled > SMAX)
            return 1'b0;
        res = neg ? 64'd0 - scaled : scaled;
        return 1'b1;
    endfunction

    function automatic logic sum_ok(input logic [63:0] a, input logic [63:0] b,
                                    output logic [63:0] r);
        r = a + b;
        return !(a[63] == b[63] && r[63] != a[63]);
    endfunction

    function automatic logic diff_ok(input logic [63:0] a, input logic [63:0] b,
                                     output logic [63:0] r);
        r = a - b;
        return !(a[63] != b[63] && r[63] != a[63]);
    endfunction

    // one unit in, one expected result out; updates the timeline state
    function automatic result_t normalize_unit(input unit_t u);
        result_t     r;
        logic [63:0] ticks, offs, base, npts, ndts, us, clk_us;
        r = '0;
        r.discontinuity_out = u.discontinuity_in;
        if (u.pts_scale == 0 || u.dts_scale != u.pts_scale)
        begin
            r.status = ST_BAD_SCALE;
            return r;
        end
        if (!org_valid)
        begin
            org_valid = 1'b1;
            org_ntp   = u.ntp_time;
            org_pts   = u.pts_ticks;
            org_scale = u.pts_scale;
        end
        if (!ntp_to_ticks(u.ntp_time, org_ntp, u.pts_scale, ticks)
            || !rescale_ticks(org_pts, org_scale, u.pts_scale, offs))
        begin
            r.status = ST_NORM_OVF;
            return r;
        end
        if (!diff_ok(ticks, offs, base) || !sum_ok(base, u.pts_ticks, npts)
            || !sum_ok(base, u.dts_ticks, ndts))
        begin
            r.status = ST_RANGE;
            return r;
        end
        r.status   = ST_OK;
        r.norm_pts = npts;
        r.norm_dts = ndts;
        if (u.is_video && u.has_wall_clock)
        begin
            if (rescale_ticks(u.pts_ticks, u.pts_scale, US_PER_SECOND, us)
                && sum_ok(u.wall_clock_us, us, clk_us))
            begin
                r.clock_us = clk_us;
                if (!seq_valid || seq_last != u.mpu_sequence || u.discontinuity_in)
                begin
                    seq_valid    = 1'b1;
                    seq_last     = u.mpu_sequence;
                    r.clock_emit = 1'b1;
                end
            end
            else
                r.clock_overflow = 1'b1;
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            org_valid    = 1'b0;
            org_ntp      = '0;
            org_pts      = '0;
            org_scale    = 32'd1;
            seq_valid    = 1'b0;
            seq_last     = '0;
            errors       <= 0;
            results_seen <= 0;
            expected_results.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== result)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        errors <= errors + 1;
                    end
                end
            end
            if (unit_valid && unit_ready)
                expected_results = {expected_results, normalize_unit(unit)};
        end
    end
endmodule

FILE: tb/access_unit_timestamp_normalizer_test.sv
// testbench top for the timestamp normalizer: stimulus, pressure phases and verdict
module access_unit_timestamp_normalizer_test;
    import autn_pkg::*;

    localparam int RANDOM_UNITS = 1330;
    localparam int CYCLE_LIMIT  = 5000000;

    logic    clk;
    logic    rst_n;
    logic    unit_valid;
    logic    unit_ready;
    unit_t   unit;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    int      errors;
    int      pending;
    int      results_seen;
    int      cycle_count = 0;
    int      units_sent;
    // number of long receiver holds asked for so far
    int      hold_request;

    access_unit_timestamp_normalizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .unit_valid   (unit_valid),
        .unit_ready   (unit_ready),
        .unit         (unit),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    access_unit_timestamp_normalizer_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .unit_valid   (unit_valid),
        .unit_ready   (unit_ready),
        .unit         (unit),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // timescales used by real streams, plus odd and extreme ones
    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return 32'd90000;
            1: return 32'd1000;
            2: return 32'd48000;
            3: return 32'd1;
            4: return 32'hFFFF_FFFF;
            5: return 32'd27000000;
            default: return $urandom_range(1, 200000);
        endcase
    endfunction

    // well-formed unit near the origin: small ntp steps and modest tick values
    function automatic unit_t sane_unit(input logic [63:0] ntp_base);
        unit_t u;
        u = '0;
        u.ntp_time         = ntp_base + {$urandom_range(0, 30), $urandom()};
        u.pts_scale        = ($urandom_range(0, 3) == 0) ? pick_scale() : 32'd90000;
        u.dts_scale        = u.pts_scale;
        u.pts_ticks        = $signed({{32{1'b0}}, $urandom()}) - 64'sd1000000;
        u.dts_ticks        = u.pts_ticks - 64'($urandom_range(0, 9000));
        u.is_video         = $urandom_range(0, 3) != 0;
        u.has_wall_clock   = $urandom_range(0, 3) != 0;
        u.wall_clock_us    = {1'b0, 31'($urandom()), $urandom()} >> $urandom_range(0, 20);
        u.mpu_sequence     = $urandom_range(0, 7);
        u.discontinuity_in = $urandom_range(0, 9) == 0;
        return u;
    endfunction

    function automatic unit_t noise_unit();
        unit_t u;
        u.ntp_time         = rand64();
        u.pts_ticks        = rand64();
        u.dts_ticks        = rand64();
        u.pts_scale        = $urandom();
        u.dts_scale        = ($urandom_range(0, 2) == 0) ? $urandom() : u.pts_scale;
        u.is_video         = 1'($urandom_range(0, 1));
        u.has_wall_clock   = 1'($urandom_range(0, 1));
        u.wall_clock_us    = rand64();
        u.mpu_sequence     = $urandom();
        u.discontinuity_in = 1'($urandom_range(0, 1));
        return u;
    endfunction

    // valid stays up after the beat until the next gap or drain lowers it
    task automatic send_unit(input unit_t u, input logic gaps);
        int idle;
        idle = gaps ? gap_len() : 0;
        if (idle != 0)
        begin
            unit_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit       <= u;
        @(posedge clk);
        while (!unit_ready) @(posedge clk);
        units_sent++;
    endtask

    task automatic drain_results();
        unit_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls, long hold when asked
    initial
    begin
        int stall;
        int holds_done;
        holds_done = 0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request != holds_done)
            begin
                result_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                holds_done++;
            end
            stall = (cycle_count % 20000 < 4000) ? 0 : gap_len();
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        unit_t u;
        logic [63:0] ntp_base;
        units_sent   = 0;
        hold_request = 0;
        rst_n        = 1'b0;
        unit_valid   = 1'b0;
        unit         = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad timescale first: zero scale, then mismatched scales, no origin latched
        u = sane_unit(64'h0000_1000_0000_0000);
        u.pts_scale = 0;
        u.dts_scale = 0;
        send_unit(u, 1'b0);
        u.pts_scale = 32'd90000;
        u.dts_scale = 32'd90001;
        send_unit(u, 1'b0);
        // origin latch with a video clock, then same sequence (no emit), then new one
        ntp_base = 64'h0000_1000_0000_0000;
        u = sane_unit(ntp_base);
        u.ntp_time = ntp_base;
        u.pts_scale = 32'd90000;
        u.dts_scale = 32'd90000;
        u.is_video = 1'b1;
        u.has_wall_clock = 1'b1;
        u.mpu_sequence = 5;
        u.discontinuity_in = 1'b0;
        send_unit(u, 1'b0);
        u.ntp_time = ntp_base + 64'h0000_0001_8000_0000;
        send_unit(u, 1'b0);
        // discontinuity forces an emit on the same sequence
        u.discontinuity_in = 1'b1;
        send_unit(u, 1'b0);
        u.discontinuity_in = 1'b0;
        u.mpu_sequence = 32'hFFFF_FFFF;
        send_unit(u, 1'b0);
        // negative delta: ntp before origin
        u.ntp_time = ntp_base - 64'h0000_0003_4000_0000;
        send_unit(u, 1'b0);
        // clock overflow: huge wall clock plus positive pts
        u.ntp_time = ntp_base;
        u.wall_clock_us = 64'h7FFF_FFFF_FFFF_FF00;
        u.pts_ticks = 64'sd90000000;
        u.dts_ticks = 64'sd90000000;
        send_unit(u, 1'b0);
        // non-video and no wall clock: no mapping
        u.wall_clock_us = 64'sd12345;
        u.is_video = 1'b0;
        send_unit(u, 1'b0);
        u.is_video = 1'b1;
        u.has_wall_clock = 1'b0;
        send_unit(u, 1'b0);
        // normalization overflow: ntp delta far away at max scale
        u.ntp_time = 64'hFFFF_FFFF_FFFF_FFFF;
        u.pts_scale = 32'hFFFF_FFFF;
        u.dts_scale = 32'hFFFF_FFFF;
        send_unit(u, 1'b0);
        // origin pts rescaled to max scale (origin scale 90000), still within range
        u.ntp_time = ntp_base;
        send_unit(u, 1'b0);
        // result out of range: pts at the extremes
        u.pts_scale = 32'd90000;
        u.dts_scale = 32'd90000;
        u.pts_ticks = 64'h7FFF_FFFF_FFFF_FFFF;
        u.dts_ticks = 64'h8000_0000_0000_0000;
        u.ntp_time = ntp_base + 64'h0000_0100_0000_0000;
        send_unit(u, 1'b0);
        u.ntp_time = ntp_base - 64'h0000_0100_0000_0000;
        send_unit(u, 1'b0);
        // rounding of negative pts in the clock mapping, scale 1 and scale 3
        u.ntp_time = ntp_base;
        u.pts_ticks = -64'sd7;
        u.dts_ticks = -64'sd7;
        u.pts_scale = 32'd3;
        u.dts_scale = 32'd3;
        u.has_wall_clock = 1'b1;
        u.mpu_sequence = 0;
        send_unit(u, 1'b0);
        u.pts_scale = 32'd1;
        u.dts_scale = 32'd1;
        u.pts_ticks = 64'h8000_0000_0000_0000;
        send_unit(u, 1'b0);
        u.ntp_time = 64'd0;
        u.wall_clock_us = 64'h8000_0000_0000_0000;
        u.pts_ticks = 64'sd0;
        send_unit(u, 1'b0);
        drain_results();

        // the sender pauses here until everything is back, then random phases
        for (int i = 0; i < RANDOM_UNITS; i++)
        begin
            if (i == 300)
            begin
                // long receiver hold while units keep coming, to fill the block
                hold_request <= hold_request + 1;
            end
            if (i == 700)
                drain_results();
            if ($urandom_range(0, 9) < 8)
                u = sane_unit(ntp_base);
            else
                u = noise_unit();
            send_unit(u, i % 400 < 60 ? 1'b0 : 1'b1);
        end

        drain_results();
        repeat (600) @(posedge clk);
        $display("sent %0d access units, checked %0d results over %0d cycles",
                 units_sent, results_seen, cycle_count);
        $display("covered bad scales, origin latch, overflow paths and clock emits");
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
